FILE: rtl/frm_pkg.sv
`default_nettype none

package frm_pkg;

    localparam int unsigned FRM_TICK_HZ         = 1000000;
    localparam int unsigned FRM_MIN_DELTA_TICKS = 10;

    localparam int TIME_W     = 32;
    localparam int TALLY_W    = 24;
    localparam int RATE_W     = 24;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 32;
    localparam int DIVD_W     = RATE_W + TIME_W;
    localparam int BIT_CNT_W  = $clog2(TIME_W);

    localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(1000000);

    localparam logic [CFG_ADDR_W-1:0] REG_MEASURE_ENABLE = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_TICKS   = CFG_ADDR_W'(1);

    typedef struct packed {
        logic done;
        logic report;
    } t_front_status;

    typedef struct packed {
        logic [TALLY_W-1:0] tally;
        logic [TIME_W-1:0]  accum;
        logic [TIME_W-1:0]  longest;
    } t_window_stats;

endpackage

`default_nettype wire

FILE: rtl/frm_ifs.sv
`default_nettype none

interface frm_in_if import frm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [TIME_W-1:0] timestamp;

    modport source (output valid, action, timestamp, input ready);
    modport sink (input valid, action, timestamp, output ready);
endinterface

interface frm_out_if import frm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] elapsed_ticks;
    logic [TIME_W-1:0] delta_ticks;
    logic              report_valid;
    logic [RATE_W-1:0] average_rate;
    logic [RATE_W-1:0] worst_rate;

    modport source (output valid, elapsed_ticks, delta_ticks, report_valid, average_rate,
                    worst_rate, input ready);
    modport sink (input valid, elapsed_ticks, delta_ticks, report_valid, average_rate,
                  worst_rate, output ready);
endinterface

interface frm_cfg_if import frm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/frm_serial_div.sv
`default_nettype none

module frm_serial_div import frm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIVD_W-1:0] i_dividend,
    input  wire logic [TIME_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [RATE_W-1:0]      o_quot
);

    localparam int QCNT_W = $clog2(RATE_W);

    logic              r_busy;
    logic              r_done;
    logic [QCNT_W-1:0] r_cnt;
    logic [TIME_W-1:0] r_rem;
    logic [TIME_W-1:0] r_div;
    logic [RATE_W-1:0] r_lo;
    logic [RATE_W-1:0] r_quot;

    logic [TIME_W-1:0] hi_part;
    logic              overflow;
    logic [TIME_W:0]   trial;
    logic [TIME_W+1:0] diff;
    logic              fits;

    always_comb begin
        hi_part  = i_dividend[DIVD_W-1:RATE_W];
        overflow = (hi_part >= i_divisor);
        trial    = {r_rem, r_lo[RATE_W-1]};
        diff     = {1'b0, trial} - {2'b00, r_div};
        fits     = ~diff[TIME_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // quotient would not fit: saturate without iterating
                r_busy <= ~overflow;
                r_done <= overflow;
            end else if (r_busy && r_cnt == QCNT_W'(RATE_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= '0;
            r_rem  <= hi_part;
            r_div  <= i_divisor;
            r_lo   <= i_dividend[RATE_W-1:0];
            r_quot <= overflow ? '1 : '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + QCNT_W'(1);
            r_rem  <= fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
            r_lo   <= {r_lo[RATE_W-2:0], 1'b0};
            r_quot <= {r_quot[RATE_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

FILE: rtl/frm_front.sv
`default_nettype none

module frm_front import frm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_action,
    input  wire logic [TIME_W-1:0] i_timestamp,
    input  wire logic [TIME_W-1:0] i_window,
    input  wire logic              i_measure_en,
    output t_front_status          o_status,
    output logic [TIME_W-1:0]      o_elapsed,
    output logic [TIME_W-1:0]      o_delta,
    output t_window_stats          o_stats
);

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_SHIFT = 2'd1;
    localparam logic [1:0] F_FIN   = 2'd2;

    logic [1:0]           r_state;
    logic [BIT_CNT_W-1:0] r_bit;
    logic                 r_restart;
    logic [TIME_W-1:0]    r_ts;
    logic [TIME_W-1:0]    r_base;
    logic [TIME_W-1:0]    r_last;
    logic [TIME_W-1:0]    r_delta;
    logic [TIME_W-1:0]    r_acc;
    logic [TALLY_W-1:0]   r_tally;
    logic [TIME_W-1:0]    r_longest;
    logic                 r_c_el;
    logic                 r_c_dl;
    logic                 r_c_sum;
    logic                 r_c_cmp;
    logic                 r_gt;

    logic               ts_b, nbase, el_bit, el_cy;
    logic               nlast, dl_bit, dl_cy;
    logic               acc_b, sum_bit, sum_cy;
    logic               nwin, cmp_cy;
    logic               measuring, reached;
    logic [TIME_W-1:0]  acc_sat;
    logic [TALLY_W-1:0] tally_inc;
    logic [TIME_W-1:0]  longest_new;

    // one bit a cycle, lsb first: elapsed, delta, accumulator and window compare
    always_comb begin
        ts_b    = r_ts[0];
        nbase   = ~r_base[0];
        el_bit  = ts_b ^ nbase ^ r_c_el;
        el_cy   = (ts_b & nbase) | (ts_b & r_c_el) | (nbase & r_c_el);
        nlast   = ~r_last[0];
        dl_bit  = el_bit ^ nlast ^ r_c_dl;
        dl_cy   = (el_bit & nlast) | (el_bit & r_c_dl) | (nlast & r_c_dl);
        acc_b   = r_acc[0];
        sum_bit = acc_b ^ dl_bit ^ r_c_sum;
        sum_cy  = (acc_b & dl_bit) | (acc_b & r_c_sum) | (dl_bit & r_c_sum);
        nwin    = ~i_window[r_bit];
        cmp_cy  = (sum_bit & nwin) | (sum_bit & r_c_cmp) | (nwin & r_c_cmp);

        measuring   = i_measure_en & ~r_restart;
        acc_sat     = r_c_sum ? '1 : r_acc;
        // an overflowed sum is saturated and always reaches the window
        reached     = r_c_sum | r_c_cmp;
        tally_inc   = (&r_tally) ? r_tally : r_tally + TALLY_W'(1);
        longest_new = r_gt ? r_delta : r_longest;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_restart <= 1'b0;
            r_base    <= '0;
            r_last    <= '0;
            r_acc     <= '0;
            r_tally   <= '0;
            r_longest <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_start) begin
                        r_restart <= i_action;
                        if (i_action) begin
                            r_base  <= i_timestamp;
                            r_last  <= '0;
                            r_state <= F_FIN;
                        end else begin
                            r_state <= F_SHIFT;
                        end
                    end
                end
                F_SHIFT: begin
                    r_base    <= {r_base[0], r_base[TIME_W-1:1]};
                    r_last    <= {el_bit, r_last[TIME_W-1:1]};
                    r_acc     <= measuring ? {sum_bit, r_acc[TIME_W-1:1]}
                                           : {r_acc[0], r_acc[TIME_W-1:1]};
                    r_longest <= {r_longest[0], r_longest[TIME_W-1:1]};
                    if (r_bit == BIT_CNT_W'(TIME_W - 1)) begin
                        r_state <= F_FIN;
                    end
                end
                F_FIN: begin
                    if (measuring) begin
                        if (reached) begin
                            r_acc     <= '0;
                            r_tally   <= '0;
                            r_longest <= '0;
                        end else begin
                            r_acc     <= acc_sat;
                            r_tally   <= tally_inc;
                            r_longest <= longest_new;
                        end
                    end
                    r_state <= F_IDLE;
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_start) begin
            r_ts    <= i_timestamp;
            r_bit   <= '0;
            r_c_el  <= 1'b1;
            r_c_dl  <= 1'b1;
            r_c_sum <= 1'b0;
            r_c_cmp <= 1'b1;
            r_gt    <= 1'b0;
            if (i_action) begin
                r_delta <= '0;
            end
        end else if (r_state == F_SHIFT) begin
            r_ts    <= {1'b0, r_ts[TIME_W-1:1]};
            r_bit   <= r_bit + BIT_CNT_W'(1);
            r_delta <= {dl_bit, r_delta[TIME_W-1:1]};
            r_c_el  <= el_cy;
            r_c_dl  <= dl_cy;
            r_c_sum <= sum_cy;
            r_c_cmp <= cmp_cy;
            // highest differing bit decides delta > longest
            if (dl_bit != r_longest[0]) begin
                r_gt <= dl_bit;
            end
        end
    end

    always_comb begin
        o_status.done   = (r_state == F_FIN);
        o_status.report = (r_state == F_FIN) & measuring & reached;
        o_stats.tally   = tally_inc;
        o_stats.accum   = acc_sat;
        o_stats.longest = longest_new;
    end

    assign o_elapsed = r_last;
    assign o_delta   = r_delta;

endmodule

`default_nettype wire

FILE: rtl/frm_rate.sv
`default_nettype none

module frm_rate import frm_pkg::*; #(
    parameter int unsigned TICK_HZ         = FRM_TICK_HZ,
    parameter int unsigned MIN_DELTA_TICKS = FRM_MIN_DELTA_TICKS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire t_window_stats i_stats,
    output logic               o_done,
    output logic [RATE_W-1:0]  o_average,
    output logic [RATE_W-1:0]  o_worst
);

    localparam int K_W       = $clog2(TICK_HZ + 1);
    localparam int PROD_W    = TALLY_W + K_W;
    localparam int MUL_STEPS = TALLY_W / 2;
    localparam int STEP_W    = $clog2(MUL_STEPS);

    localparam logic [PROD_W-1:0] K1 = PROD_W'(TICK_HZ);
    localparam logic [PROD_W-1:0] K2 = K1 << 1;
    localparam logic [PROD_W-1:0] K3 = K1 + K2;

    localparam logic [TIME_W-1:0] MIN_DEN  = TIME_W'(MIN_DELTA_TICKS);
    localparam logic [DIVD_W-1:0] TICK_DVD = DIVD_W'(TICK_HZ);

    localparam logic [1:0] R_IDLE   = 2'd0;
    localparam logic [1:0] R_MUL    = 2'd1;
    localparam logic [1:0] R_LAUNCH = 2'd2;
    localparam logic [1:0] R_WAIT   = 2'd3;

    logic [1:0]         r_state;
    logic [STEP_W-1:0]  r_cnt;
    logic [TALLY_W-1:0] r_mplier;
    logic [PROD_W-1:0]  r_prod;
    logic [TIME_W-1:0]  r_accum;
    logic               r_avg_seen;
    logic               r_worst_seen;

    logic [TIME_W-1:0] den;
    logic [PROD_W-1:0] partial;
    logic [PROD_W-1:0] prod_next;
    logic              worst_done;
    logic [RATE_W-1:0] worst_q;
    logic              avg_done;
    logic [RATE_W-1:0] avg_q;
    logic              both_done;

    always_comb begin
        den = (i_stats.longest < MIN_DEN) ? MIN_DEN : i_stats.longest;
        case (r_mplier[TALLY_W-1 -: 2])
            2'd0:    partial = '0;
            2'd1:    partial = K1;
            2'd2:    partial = K2;
            2'd3:    partial = K3;
            default: partial = '0;
        endcase
        // radix-4 shift-add, msb digit first
        prod_next = {r_prod[PROD_W-3:0], 2'b00} + partial;
        // a saturated average finishes early, so wait for both dividers
        both_done = (r_avg_seen | avg_done) & (r_worst_seen | worst_done);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
        end else begin
            case (r_state)
                R_IDLE: begin
                    if (i_start) begin
                        r_state <= R_MUL;
                    end
                end
                R_MUL: begin
                    if (r_cnt == STEP_W'(MUL_STEPS - 1)) begin
                        r_state <= R_LAUNCH;
                    end
                end
                R_LAUNCH: begin
                    r_state <= R_WAIT;
                end
                R_WAIT: begin
                    if (both_done) begin
                        r_state <= R_IDLE;
                    end
                end
                default: begin
                    r_state <= R_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == R_IDLE && i_start) begin
            r_cnt    <= '0;
            r_mplier <= i_stats.tally;
            r_prod   <= '0;
            r_accum  <= i_stats.accum;
        end else if (r_state == R_MUL) begin
            r_cnt    <= r_cnt + STEP_W'(1);
            r_mplier <= {r_mplier[TALLY_W-3:0], 2'b00};
            r_prod   <= prod_next;
        end
        if (r_state == R_IDLE && i_start) begin
            r_avg_seen   <= 1'b0;
            r_worst_seen <= 1'b0;
        end else begin
            if (avg_done) begin
                r_avg_seen <= 1'b1;
            end
            if (worst_done) begin
                r_worst_seen <= 1'b1;
            end
        end
    end

    frm_serial_div u_worst_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start && r_state == R_IDLE),
        .i_dividend (TICK_DVD),
        .i_divisor  (den),
        .o_done     (worst_done),
        .o_quot     (worst_q)
    );

    frm_serial_div u_avg_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == R_LAUNCH),
        .i_dividend (DIVD_W'(r_prod)),
        .i_divisor  (r_accum),
        .o_done     (avg_done),
        .o_quot     (avg_q)
    );

    // both quotients hold until the next start
    assign o_done    = (r_state == R_WAIT) & both_done;
    assign o_average = avg_q;
    assign o_worst   = worst_q;

endmodule

`default_nettype wire

FILE: rtl/frame_rate_monitor.sv
// Frame timing monitor with windowed rate statistics.
// i_in carries one word per frame event: action (0 frame, 1 restart) and a
// free-running timestamp. o_out returns one word per input word: elapsed and
// delta ticks, and on a window close the average and worst rates.
// i_cfg writes register 0 (measure enable, bit 0) and register 1 (window
// length in ticks); other addresses are dropped. i_cfg is always ready and
// must only be written while no frame is in flight.
// A restart word only loads the new baseline and passes the finish and
// load states to o_out. A frame word runs the bit-serial time datapath first
// (one bit per cycle over 32 bits); a frame that closes a window adds the
// radix-4 multiply, a launch state, the serial divider (one quotient bit per
// cycle, 24 bits) and a hand-off, or only the worst-rate divide when the
// average saturates. One word is worked on at a time; i_in.ready rises again
// once the result has moved into the output register. A stalled receiver
// holds that register and blocks only the hand-off of the following result.
// Reset clears the baseline, the statistics, measure enable and sets the
// window to 1000000 ticks.
`default_nettype none

module frame_rate_monitor import frm_pkg::*; #(
    parameter int unsigned TICK_HZ         = FRM_TICK_HZ,
    parameter int unsigned MIN_DELTA_TICKS = FRM_MIN_DELTA_TICKS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    frm_in_if.sink    i_in,
    frm_out_if.source o_out,
    frm_cfg_if.sink   i_cfg
);

    localparam logic [1:0] T_IDLE  = 2'd0;
    localparam logic [1:0] T_FRONT = 2'd1;
    localparam logic [1:0] T_RATE  = 2'd2;
    localparam logic [1:0] T_LOAD  = 2'd3;

    logic [1:0]        r_state;
    logic              r_measure_en;
    logic [TIME_W-1:0] r_window;
    logic              r_report;
    logic              r_out_valid;
    logic [TIME_W-1:0] r_out_elapsed;
    logic [TIME_W-1:0] r_out_delta;
    logic              r_out_report;
    logic [RATE_W-1:0] r_out_average;
    logic [RATE_W-1:0] r_out_worst;

    logic              in_accept;
    logic              can_load;
    t_front_status     front_status;
    t_window_stats     front_stats;
    logic [TIME_W-1:0] front_elapsed;
    logic [TIME_W-1:0] front_delta;
    logic              rate_start;
    logic              rate_done;
    logic [RATE_W-1:0] rate_average;
    logic [RATE_W-1:0] rate_worst;

    assign i_in.ready  = (r_state == T_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_accept   = i_in.valid & i_in.ready;
    assign can_load    = ~r_out_valid | o_out.ready;
    assign rate_start  = (r_state == T_FRONT) & front_status.done & front_status.report;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_measure_en <= 1'b0;
            r_window     <= WINDOW_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                REG_MEASURE_ENABLE: r_measure_en <= i_cfg.data[0];
                REG_WINDOW_TICKS:   r_window     <= i_cfg.data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_report    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                T_IDLE: begin
                    if (in_accept) begin
                        r_state <= T_FRONT;
                    end
                end
                T_FRONT: begin
                    if (front_status.done) begin
                        r_report <= front_status.report;
                        r_state  <= front_status.report ? T_RATE : T_LOAD;
                    end
                end
                T_RATE: begin
                    if (rate_done) begin
                        r_state <= T_LOAD;
                    end
                end
                T_LOAD: begin
                    if (can_load) begin
                        r_state <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase

            if (r_state == T_LOAD && can_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == T_LOAD && can_load) begin
            r_out_elapsed <= front_elapsed;
            r_out_delta   <= front_delta;
            r_out_report  <= r_report;
            r_out_average <= r_report ? rate_average : '0;
            r_out_worst   <= r_report ? rate_worst : '0;
        end
    end

    frm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (in_accept),
        .i_action     (i_in.action),
        .i_timestamp  (i_in.timestamp),
        .i_window     (r_window),
        .i_measure_en (r_measure_en),
        .o_status     (front_status),
        .o_elapsed    (front_elapsed),
        .o_delta      (front_delta),
        .o_stats      (front_stats)
    );

    frm_rate #(
        .TICK_HZ         (TICK_HZ),
        .MIN_DELTA_TICKS (MIN_DELTA_TICKS)
    ) u_rate (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (rate_start),
        .i_stats   (front_stats),
        .o_done    (rate_done),
        .o_average (rate_average),
        .o_worst   (rate_worst)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.elapsed_ticks = r_out_elapsed;
    assign o_out.delta_ticks   = r_out_delta;
    assign o_out.report_valid  = r_out_report;
    assign o_out.average_rate  = r_out_average;
    assign o_out.worst_rate    = r_out_worst;

    a_front_done_in_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_status.done |-> r_state == T_FRONT)
        else $error("time datapath finished outside its phase");

    a_rate_done_in_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rate_done |-> r_state == T_RATE)
        else $error("rate unit finished outside its phase");

    a_no_report_zero_rates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_report) |-> (r_out_average == '0 && r_out_worst == '0))
        else $error("rates shown without a closed window");

    a_accept_starts_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == T_FRONT)
        else $error("accepted word did not start the time datapath");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import frm_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASE_WORDS = 300;

    typedef enum logic {
        ACT_FRAME   = 1'b0,
        ACT_RESTART = 1'b1
    } t_frame_action;

    typedef struct packed {
        logic [TIME_W-1:0] elapsed_ticks;
        logic [TIME_W-1:0] delta_ticks;
        logic              report_valid;
        logic [RATE_W-1:0] average_rate;
        logic [RATE_W-1:0] worst_rate;
    } t_frame_report;

    logic i_clk;
    logic i_rst_n;

    frm_in_if  in_if ();
    frm_out_if out_if ();
    frm_cfg_if cfg_if ();

    frame_rate_monitor DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // timing state and statistics as the block should hold them
    logic               stats_enabled;
    logic [TIME_W-1:0]  window_len;
    logic [TIME_W-1:0]  base_ts;
    logic [TIME_W-1:0]  prev_elapsed;
    logic [TIME_W-1:0]  accum_ticks;
    logic [TALLY_W-1:0] frame_count;
    logic [TIME_W-1:0]  peak_delta;

    t_frame_report expected_reports[$];
    int            mismatch_count;
    int            cycle_count;
    bit            jitter_on;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic predict_frame_report(t_frame_action act, logic [TIME_W-1:0] ts);
        t_frame_report     r;
        logic [TIME_W:0]   sum;
        logic [63:0]       q;
        logic [TIME_W-1:0] den;
        r = '0;
        if (act == ACT_RESTART) begin
            base_ts = ts;
            prev_elapsed = '0;
        end else begin
            r.elapsed_ticks = ts - base_ts;
            r.delta_ticks = r.elapsed_ticks - prev_elapsed;
            prev_elapsed = r.elapsed_ticks;
            if (stats_enabled) begin
                sum = {1'b0, accum_ticks} + {1'b0, r.delta_ticks};
                accum_ticks = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                if (frame_count != '1) begin
                    frame_count = frame_count + 1'b1;
                end
                if (r.delta_ticks > peak_delta) begin
                    peak_delta = r.delta_ticks;
                end
                if (accum_ticks >= window_len) begin
                    r.report_valid = 1'b1;
                    if (accum_ticks == '0) begin
                        r.average_rate = '1;
                    end else begin
                        q = (64'(frame_count) * 64'(FRM_TICK_HZ)) / 64'(accum_ticks);
                        r.average_rate = (q > 64'(24'hFF_FFFF)) ? '1 : q[RATE_W-1:0];
                    end
                    den = (peak_delta < FRM_MIN_DELTA_TICKS) ? FRM_MIN_DELTA_TICKS : peak_delta;
                    q = 64'(FRM_TICK_HZ) / 64'(den);
                    r.worst_rate = (q > 64'(24'hFF_FFFF)) ? '1 : q[RATE_W-1:0];
                    accum_ticks = '0;
                    frame_count = '0;
                    peak_delta = '0;
                end
            end
        end
        expected_reports.push_back(r);
    endtask

    // track register writes and accepted words at the clock edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                if (cfg_if.addr == REG_MEASURE_ENABLE) begin
                    stats_enabled = cfg_if.data[0];
                end else if (cfg_if.addr == REG_WINDOW_TICKS) begin
                    window_len = cfg_if.data;
                end
            end
            if (in_if.valid && in_if.ready) begin
                predict_frame_report(t_frame_action'(in_if.action), in_if.timestamp);
            end
        end
    end

    function automatic void check_field(string fname, logic [TIME_W-1:0] want,
                                        logic [TIME_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_frame_report want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_reports.size() == 0) begin
                $error("result word with nothing expected: elapsed 0x%0h",
                       out_if.elapsed_ticks);
                mismatch_count++;
            end else begin
                want = expected_reports.pop_front();
                check_field("elapsed_ticks", want.elapsed_ticks, out_if.elapsed_ticks);
                check_field("delta_ticks", want.delta_ticks, out_if.delta_ticks);
                check_field("report_valid", TIME_W'(want.report_valid),
                            TIME_W'(out_if.report_valid));
                check_field("average_rate", TIME_W'(want.average_rate),
                            TIME_W'(out_if.average_rate));
                check_field("worst_rate", TIME_W'(want.worst_rate),
                            TIME_W'(out_if.worst_rate));
            end
        end
    end

    always @(negedge i_clk) begin
        out_if.ready <= !(jitter_on && $urandom_range(0, 99) < 20);
    end

    // valid is left high after the handshake; the next call or drain_results decides
    task automatic send_word(t_frame_action act, logic [TIME_W-1:0] ts);
        @(negedge i_clk);
        if (jitter_on && $urandom_range(0, 99) < 20) begin
            in_if.valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < 20);
        end
        in_if.valid <= 1'b1;
        in_if.action <= act;
        in_if.timestamp <= ts;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_reports.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.addr <= addr;
        cfg_if.data <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // measuring is off after reset: only elapsed and delta, including wraparound
    task automatic test_time_only();
        send_word(ACT_FRAME, 32'h0000_0000);
        send_word(ACT_FRAME, 32'd100);
        send_word(ACT_FRAME, 32'hFFFF_FFFF);
        send_word(ACT_RESTART, 32'hFFFF_FFF0);
        send_word(ACT_FRAME, 32'h0000_0010);
        send_word(ACT_RESTART, 32'h0000_0000);
        send_word(ACT_FRAME, 32'h7FFF_FFFF);
    endtask

    task automatic test_window_close();
        drain_results();
        write_reg(REG_MEASURE_ENABLE, 32'hFFFF_FFFF);
        write_reg(REG_WINDOW_TICKS, 32'd1);
        send_word(ACT_RESTART, 32'd1000);
        send_word(ACT_FRAME, 32'd1005);
        send_word(ACT_FRAME, 32'd4005);
        // zero-delta frames pile up the tally until the average saturates
        repeat (16) send_word(ACT_FRAME, 32'd4005);
        send_word(ACT_FRAME, 32'd4006);
        drain_results();
        write_reg(REG_WINDOW_TICKS, 32'd0);
        send_word(ACT_FRAME, 32'd4006);
        drain_results();
        write_reg(REG_WINDOW_TICKS, 32'hFFFF_FFFF);
        send_word(ACT_FRAME, 32'd4006 + 32'h8000_0000);
        send_word(ACT_FRAME, 32'd4006 + 32'h8000_0000 + 32'h9000_0000);
    endtask

    task automatic test_register_map();
        drain_results();
        write_reg(8'hFF, 32'h0000_0000);
        write_reg(8'd2, 32'hFFFF_FFFF);
        write_reg(REG_MEASURE_ENABLE, 32'hFFFF_FFFE);
        send_word(ACT_FRAME, 32'h1234_5678);
        drain_results();
        write_reg(REG_WINDOW_TICKS, 32'd500);
        write_reg(REG_MEASURE_ENABLE, 32'h0000_0001);
        send_word(ACT_FRAME, 32'h1234_5678 + 32'd200);
        send_word(ACT_FRAME, 32'h1234_5678 + 32'd700);
    endtask

    task automatic send_random_frame(ref logic [TIME_W-1:0] now);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            if (pick < 2) begin
                now = $urandom;
            end
            send_word(ACT_RESTART, now);
        end else begin
            if (pick < 75) begin
                now = now + $urandom_range(1, 3000);
            end else if (pick < 85) begin
                now = now + $urandom_range(0, 12);
            end else if (pick < 95) begin
                now = now + $urandom;
            end else begin
                now = $urandom;
            end
            send_word(ACT_FRAME, now);
        end
    endtask

    task automatic test_random_traffic();
        logic [TIME_W-1:0]     now;
        logic [CFG_DATA_W-1:0] en_word;
        logic [TIME_W-1:0]     win;
        now = $urandom;
        for (int phase = 0; phase < 6; phase++) begin
            en_word = $urandom;
            en_word[0] = (phase != 2);
            case (phase)
                0: win = $urandom_range(1000, 20000);
                1: win = 32'd1;
                3: win = 32'hFFFF_FFFF;
                4: win = $urandom_range(1, 50000);
                default: win = $urandom;
            endcase
            drain_results();
            write_reg(REG_MEASURE_ENABLE, en_word);
            write_reg(REG_WINDOW_TICKS, win);
            // first phase runs without random idling on either side
            jitter_on = (phase != 0);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_random_frame(now);
                if (n == PHASE_WORDS / 2) begin
                    drain_results();
                end
            end
        end
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.action = ACT_FRAME;
        in_if.timestamp = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.addr = '0;
        cfg_if.data = '0;
        stats_enabled = 1'b0;
        window_len = WINDOW_RESET;
        base_ts = '0;
        prev_elapsed = '0;
        accum_ticks = '0;
        frame_count = '0;
        peak_delta = '0;
        mismatch_count = 0;
        jitter_on = 1'b1;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_time_only();
        test_window_close();
        test_register_map();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/frm_pkg.sv
rtl/frm_ifs.sv
rtl/frm_serial_div.sv
rtl/frm_front.sv
rtl/frm_rate.sv
rtl/frame_rate_monitor.sv
tb/tb_top.sv
